// ----- rtl/utf8esc_pkg.sv -----
// ----------------------------------------------------------------------------
// utf8esc_pkg
// Job record, status codes and character helpers shared by the converter.
// ----------------------------------------------------------------------------
package utf8esc_pkg;

  // Status codes on the output channel
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BAD_LEAD = 3'd1;
  localparam logic [2:0] ST_BAD_CONT = 3'd2;
  localparam logic [2:0] ST_TRUNC    = 3'd3;
  localparam logic [2:0] ST_SURR     = 3'd4;
  localparam logic [2:0] ST_RANGE    = 3'd5;

  // Byte class limits
  localparam logic [7:0] LEAD2_MAX = 8'hDF;
  localparam logic [7:0] LEAD3_MAX = 8'hEF;
  localparam logic [7:0] LEAD4_MAX = 8'hF7;
  localparam logic [7:0] CONT_MAX  = 8'hBF;

  // Code point limits
  localparam logic [20:0] CP_ASCII_MAX = 21'h00007F;
  localparam logic [20:0] CP_BMP_MAX   = 21'h00FFFF;
  localparam logic [20:0] CP_SURR_LO   = 21'h00D800;
  localparam logic [20:0] CP_SURR_HI   = 21'h00DFFF;
  localparam logic [20:0] CP_MAX       = 21'h10FFFF;
  localparam logic [20:0] CP_SUPP_BASE = 21'h010000;
  localparam logic [15:0] HI_SURR_BASE = 16'hD800;
  localparam logic [15:0] LO_SURR_BASE = 16'hDC00;

  // Escape characters
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_A_LOW  = 8'h61;

  // Escape layout: backslash, u, four hex digits
  localparam logic [2:0] ESC_LAST_POS = 3'd5;

  typedef enum logic [1:0] {
    JOB_CHAR,   // one literal character in hi[7:0]
    JOB_FLAG,   // one result with no character, status only
    JOB_ESC1,   // one escape of hi
    JOB_ESC2    // escape of hi, then escape of lo
  } job_kind_t;

  typedef struct packed {
    job_kind_t   kind;
    logic [15:0] hi;
    logic [15:0] lo;
    logic [2:0]  status;
    logic        eos;
  } job_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] ch;
    if (nib < 4'd10) begin
      ch = CH_ZERO + {4'd0, nib};
    end else begin
      ch = CH_A_LOW + {4'd0, nib} - 8'd10;
    end
    return ch;
  endfunction

endpackage

// ----- rtl/utf8esc_ifs.sv -----
// ----------------------------------------------------------------------------
// utf8esc channel interfaces
// Valid/ready channels for the UTF-8 byte stream and the ASCII output stream.
// ----------------------------------------------------------------------------
interface utf8esc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_string;

  modport source (output valid, output in_byte, output end_of_string, input ready);
  modport sink   (input valid, input in_byte, input end_of_string, output ready);
endinterface

interface utf8esc_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       char_valid;
  logic [2:0] status;
  logic       last_of_run;
  logic       string_done;

  modport source (output valid, output out_char, output char_valid, output status,
                  output last_of_run, output string_done, input ready);
  modport sink   (input valid, input out_char, input char_valid, input status,
                  input last_of_run, input string_done, output ready);
endinterface

// ----- rtl/utf8esc_front.sv -----
// ----------------------------------------------------------------------------
// utf8esc_front
// Decodes UTF-8 bytes into code points, checks them and queues output jobs.
// ----------------------------------------------------------------------------
module utf8esc_front (
  input  logic                 clk,
  input  logic                 rst,
  utf8esc_byte_if.sink         byte_ch,
  input  logic                 q_full,
  output logic                 q_push,
  output utf8esc_pkg::job_t    q_job
);
  import utf8esc_pkg::*;

  logic [20:0] accum, accum_next;
  logic [1:0]  due, due_next;
  logic        skipping, skipping_next;

  logic        accept;
  logic        push;
  logic        done;
  logic        fail;
  logic [2:0]  fcode;
  logic [20:0] cp;
  logic [20:0] supp;
  logic [7:0]  b;
  logic        eos;
  job_t        job;

  assign b      = byte_ch.in_byte;
  assign eos    = byte_ch.end_of_string;
  assign byte_ch.ready = ~q_full;
  assign accept = byte_ch.valid & ~q_full;
  assign supp   = cp - CP_SUPP_BASE;

  always_comb begin
    accum_next    = accum;
    due_next      = due;
    skipping_next = skipping;
    push          = 1'b0;
    done          = 1'b0;
    fail          = 1'b0;
    fcode         = ST_OK;
    cp            = '0;
    job.kind      = JOB_FLAG;
    job.hi        = '0;
    job.lo        = '0;
    job.status    = ST_OK;
    job.eos       = eos;

    if (skipping) begin
      // dropping the rest of a failed string; only its end gets a result
      if (eos) begin
        push          = 1'b1;
        skipping_next = 1'b0;
        accum_next    = '0;
        due_next      = '0;
      end
    end else if (due == 2'd0) begin
      if (!b[7]) begin
        done = 1'b1;
        cp   = {13'd0, b};
      end else if (b <= CONT_MAX || b > LEAD4_MAX) begin
        fail  = 1'b1;
        fcode = ST_BAD_LEAD;
      end else begin
        if (b <= LEAD2_MAX) begin
          accum_next = {16'd0, b[4:0]};
          due_next   = 2'd1;
        end else if (b <= LEAD3_MAX) begin
          accum_next = {17'd0, b[3:0]};
          due_next   = 2'd2;
        end else begin
          accum_next = {18'd0, b[2:0]};
          due_next   = 2'd3;
        end
        fail  = eos;
        fcode = ST_TRUNC;
      end
    end else begin
      if (b[7:6] != 2'b10) begin
        fail  = 1'b1;
        fcode = ST_BAD_CONT;
      end else begin
        cp         = {accum[14:0], b[5:0]};
        accum_next = cp;
        due_next   = due - 2'd1;
        if (due == 2'd1) begin
          done = 1'b1;
        end else begin
          fail  = eos;
          fcode = ST_TRUNC;
        end
      end
    end

    if (fail) begin
      push          = 1'b1;
      job.status    = fcode;
      accum_next    = '0;
      due_next      = '0;
      skipping_next = ~eos;
    end

    if (done) begin
      push       = 1'b1;
      accum_next = '0;
      if (cp >= CP_SURR_LO && cp <= CP_SURR_HI) begin
        job.status    = ST_SURR;
        skipping_next = ~eos;
      end else if (cp > CP_MAX) begin
        job.status    = ST_RANGE;
        skipping_next = ~eos;
      end else if (cp <= CP_ASCII_MAX) begin
        job.kind = JOB_CHAR;
        job.hi   = {8'd0, cp[7:0]};
      end else if (cp <= CP_BMP_MAX) begin
        job.kind = JOB_ESC1;
        job.hi   = cp[15:0];
      end else begin
        job.kind = JOB_ESC2;
        job.hi   = HI_SURR_BASE + {6'd0, supp[19:10]};
        job.lo   = LO_SURR_BASE + {6'd0, supp[9:0]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accum    <= '0;
      due      <= '0;
      skipping <= 1'b0;
    end else if (accept) begin
      accum    <= accum_next;
      due      <= due_next;
      skipping <= skipping_next;
    end
  end

  assign q_push = accept & push;
  assign q_job  = job;

endmodule

// ----- rtl/utf8esc_fifo.sv -----
// ----------------------------------------------------------------------------
// utf8esc_fifo
// Small job queue between decoder and character sequencer.
// ----------------------------------------------------------------------------
module utf8esc_fifo #(
  parameter int DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  utf8esc_pkg::job_t push_job,
  output logic              full,
  input  logic              pop,
  output logic              avail,
  output utf8esc_pkg::job_t pop_job
);
  import utf8esc_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  job_t          mem [DEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [CW-1:0] count;

  assign full    = (count == FULL_CNT);
  assign avail   = (count != '0);
  assign pop_job = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == LAST_PTR) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == LAST_PTR) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/utf8esc_back.sv -----
// ----------------------------------------------------------------------------
// utf8esc_back
// Expands queued jobs into ASCII characters, one per cycle while char_ch is
// not stalled, into an output register.
// ----------------------------------------------------------------------------
module utf8esc_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_avail,
  input  utf8esc_pkg::job_t q_job,
  output logic              q_pop,
  utf8esc_char_if.source    char_ch
);
  import utf8esc_pkg::*;

  logic       busy;
  job_t       job;
  logic [2:0] pos;
  logic       half;

  logic       adv;
  logic       last;
  logic       take;
  logic [15:0] val;
  logic [7:0] ch;
  logic       ch_ok;

  logic       ov;
  logic [7:0] o_char;
  logic       o_cv;
  logic [2:0] o_status;
  logic       o_last;
  logic       o_done;

  assign adv = busy & (~ov | char_ch.ready);
  assign val = half ? job.lo : job.hi;

  always_comb begin
    last  = 1'b1;
    ch    = 8'd0;
    ch_ok = 1'b1;
    case (pos)
      3'd0:    ch = CH_BSLASH;
      3'd1:    ch = CH_U;
      3'd2:    ch = hex_char(val[15:12]);
      3'd3:    ch = hex_char(val[11:8]);
      3'd4:    ch = hex_char(val[7:4]);
      default: ch = hex_char(val[3:0]);
    endcase
    case (job.kind)
      JOB_CHAR: begin
        ch = job.hi[7:0];
      end
      JOB_FLAG: begin
        ch    = 8'd0;
        ch_ok = 1'b0;
      end
      JOB_ESC1: begin
        last = (pos == ESC_LAST_POS);
      end
      default: begin
        last = (pos == ESC_LAST_POS) & half;
      end
    endcase
  end

  assign take  = q_avail & (~busy | (adv & last));
  assign q_pop = take;

  always_ff @(posedge clk) begin
    if (take) begin
      job <= q_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pos  <= '0;
      half <= 1'b0;
    end else if (take) begin
      busy <= 1'b1;
      pos  <= '0;
      half <= 1'b0;
    end else if (adv) begin
      if (last) begin
        busy <= 1'b0;
      end else if (pos == ESC_LAST_POS) begin
        pos  <= '0;
        half <= 1'b1;
      end else begin
        pos <= pos + 3'd1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (adv) begin
      ov <= 1'b1;
    end else if (char_ch.ready) begin
      ov <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_char   <= ch;
      o_cv     <= ch_ok;
      o_status <= job.status;
      o_last   <= last;
      o_done   <= last & job.eos;
    end
  end

  assign char_ch.valid       = ov;
  assign char_ch.out_char    = o_char;
  assign char_ch.char_valid  = o_cv;
  assign char_ch.status      = o_status;
  assign char_ch.last_of_run = o_last;
  assign char_ch.string_done = o_done;

endmodule

// ----- rtl/utf8_to_utf16_escape.sv -----
// ----------------------------------------------------------------------------
// utf8_to_utf16_escape
// UTF-8 byte stream to ASCII text with UTF-16 backslash-u escapes.
// ----------------------------------------------------------------------------
// Takes one UTF-8 byte per request on byte_ch, the last byte of a string
// marked with end_of_string, and produces ASCII characters on char_ch. A code
// point up to 0x7F goes out as itself, one up to 0xFFFF as a six-character
// escape (backslash, u, four lowercase hex digits), a higher one as two such
// escapes for its surrogate pair. Overlong forms are accepted. A bad lead
// byte, bad continuation byte, truncated sequence, surrogate or value above
// 0x10FFFF gives one result with char_valid low and the error in status; the
// rest of that string is then dropped, and its marked last byte closes it
// with a status-0, no-character result. Characters are streamed as decoded,
// so a consumer must discard any string that carries a nonzero status.
// Throughput: a byte is taken in every cycle while the job queue has room;
// each byte yields 0, 1, 6 or 12 results and the output sequencer sends one
// result per cycle while char_ch is not stalled, so the sustained rate is
// bounded by that sequencer. A decoded job passes through the job queue,
// the sequencer's job register and the output register to reach char_ch.
// ----------------------------------------------------------------------------
module utf8_to_utf16_escape #(
  parameter int QUEUE_DEPTH = 2   // job queue entries, 2 or more
) (
  input  logic           clk,
  input  logic           rst,
  utf8esc_byte_if.sink   byte_ch,
  utf8esc_char_if.source char_ch
);
  import utf8esc_pkg::*;

  // front to queue
  logic q_push;
  logic q_full;
  job_t push_job;

  // queue to back
  logic q_pop;
  logic q_avail;
  job_t pop_job;

  // Front: decodes each byte, tracks the accumulator, continuation count
  // and skip state, and turns a finished code point or an error into a job.
  utf8esc_front u_front (
    .clk     (clk),
    .rst     (rst),
    .byte_ch (byte_ch),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_job   (push_job)
  );

  // Queue: decouples decode from the multi-cycle character expansion.
  utf8esc_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .avail    (q_avail),
    .pop_job  (pop_job)
  );

  // Back: walks each job one character per cycle, while char_ch is not stalled, into the output register.
  utf8esc_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_avail (q_avail),
    .q_job   (pop_job),
    .q_pop   (q_pop),
    .char_ch (char_ch)
  );

endmodule
